@@ rtl/hrp_pkg.sv @@
// Shared types and constants of the HTTP request head parser.
`default_nettype none

package hrp_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int POS_WIDTH = 32;
  localparam logic [7:0] DIGIT_ZERO = 8'd48;

  typedef enum logic [4:0] {
    K_NUL, K_SPC, K_WHT, K_CR, K_LF, K_COL, K_COM, K_QUO, K_BSL, K_SLH, K_PLS, K_MIN,
    K_DOT, K_DIG, K_ETC, K_STR, K_E, K_G, K_T, K_P, K_H, K_O, K_S
  } char_class_t;

  typedef enum logic [2:0] {
    EV_NONE, EV_METHOD, EV_PATH, EV_MAJOR, EV_MINOR, EV_KEY, EV_VALUE
  } event_kind_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    char_class_t cls;
  } hrp_item_t;

  // Bytes above 127 fall into the generic class.
  function automatic char_class_t classify(logic [7:0] b);
    char_class_t c;
    if (b[7]) begin
      c = K_ETC;
    end else begin
      case (b)
        8'h0A: c = K_LF;
        8'h0D: c = K_CR;
        8'h20: c = K_SPC;
        8'h22: c = K_QUO;
        8'h2A: c = K_STR;
        8'h2B: c = K_PLS;
        8'h2C: c = K_COM;
        8'h2D: c = K_MIN;
        8'h2E: c = K_DOT;
        8'h2F: c = K_SLH;
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34,
        8'h35, 8'h36, 8'h37, 8'h38, 8'h39: c = K_DIG;
        8'h3A: c = K_COL;
        8'h45: c = K_E;
        8'h47: c = K_G;
        8'h48: c = K_H;
        8'h4F: c = K_O;
        8'h50: c = K_P;
        8'h53: c = K_S;
        8'h54: c = K_T;
        8'h5C: c = K_BSL;
        8'h7F: c = K_NUL;
        default: c = (b[6:5] == 2'b00) ? K_NUL : K_ETC;
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/hrp_in_if.sv @@
// Byte input channel of the HTTP request head parser.
`default_nettype none

interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source(output valid, output data_byte, input ready);
  modport sink(input valid, input data_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/hrp_out_if.sv @@
// Result channel of the HTTP request head parser.
`default_nettype none

interface hrp_out_if;
  import hrp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 accepted;
  event_kind_t          event_kind;
  logic [3:0]           event_value;
  logic [POS_WIDTH-1:0] byte_position;

  modport source(output valid, output accepted, output event_kind, output event_value,
                 output byte_position, input ready);
  modport sink(input valid, input accepted, input event_kind, input event_value,
               input byte_position, output ready);
endinterface

`default_nettype wire

@@ rtl/hrp_front.sv @@
// Front end: accepts bytes, classifies them and queues them for the parser.
`default_nettype none

module hrp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  hrp_in_if.sink                 data,
  output hrp_pkg::hrp_item_t     q_item,
  output logic                   q_valid,
  input  wire logic              q_ready
);
  import hrp_pkg::*;

  hrp_item_t  entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign data.ready = (count != 2'd2);
  assign push = data.valid && data.ready;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr].data_byte <= data.data_byte;
      entries[wr_ptr].cls <= classify(data.data_byte);
    end
  end

endmodule

`default_nettype wire

@@ rtl/hrp_back.sv @@
// Back end: grammar state machine, byte counter and result register.
`default_nettype none

module hrp_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hrp_pkg::hrp_item_t q_item,
  input  wire logic              q_valid,
  output logic                   q_ready,
  hrp_out_if.source              result
);
  import hrp_pkg::*;

  localparam logic [3:0] METHOD_GET = 4'd0;
  localparam logic [3:0] METHOD_POST = 4'd1;

  typedef enum logic [4:0] {
    S_GO, S_G1, S_G2, S_G3, S_P1, S_P2, S_P3, S_P4, S_PT, S_H1, S_H2, S_H3, S_H4,
    S_H5, S_H6, S_H7, S_H8, S_EL, S_ER, S_HK, S_HV
  } state_t;

  typedef enum logic [2:0] {
    ACT_MOVE, ACT_GET, ACT_POST, ACT_PATH, ACT_MAJ, ACT_MIN, ACT_KEY, ACT_REJECT
  } act_t;

  typedef struct packed {
    act_t   act;
    state_t target;
  } step_t;

  function automatic step_t next_step(state_t st, char_class_t c);
    step_t r;
    r.act = ACT_REJECT;
    r.target = st;
    unique case (st)
      S_GO: begin
        if (c == K_G) begin
          r = '{ACT_MOVE, S_G1};
        end else if (c == K_P) begin
          r = '{ACT_MOVE, S_P1};
        end
      end
      S_G1: if (c == K_E) r = '{ACT_MOVE, S_G2};
      S_G2: if (c == K_T) r = '{ACT_MOVE, S_G3};
      S_G3: if (c == K_SPC) r = '{ACT_GET, S_PT};
      S_P1: if (c == K_O) r = '{ACT_MOVE, S_P2};
      S_P2: if (c == K_S) r = '{ACT_MOVE, S_P3};
      S_P3: if (c == K_T) r = '{ACT_MOVE, S_P4};
      S_P4: if (c == K_SPC) r = '{ACT_POST, S_PT};
      S_PT: begin
        if (c == K_SPC) begin
          r = '{ACT_PATH, S_H1};
        end else if (c == K_SLH || c == K_PLS || c == K_MIN || c == K_DOT ||
                     c == K_DIG || c == K_ETC || c == K_E || c == K_G ||
                     c == K_T || c == K_P || c == K_H) begin
          r = '{ACT_MOVE, S_PT};
        end
      end
      S_H1: if (c == K_H) r = '{ACT_MOVE, S_H2};
      S_H2: if (c == K_T) r = '{ACT_MOVE, S_H3};
      S_H3: if (c == K_T) r = '{ACT_MOVE, S_H4};
      S_H4: if (c == K_P) r = '{ACT_MOVE, S_H5};
      S_H5: if (c == K_SLH) r = '{ACT_MOVE, S_H6};
      S_H6: if (c == K_DIG) r = '{ACT_MAJ, S_H7};
      S_H7: if (c == K_DOT) r = '{ACT_MOVE, S_H8};
      S_H8: if (c == K_DIG) r = '{ACT_MIN, S_EL};
      S_EL: begin
        if (c == K_CR) begin
          r = '{ACT_MOVE, S_ER};
        end else if (c == K_LF) begin
          r = '{ACT_MOVE, S_HK};
        end
      end
      S_ER: if (c == K_LF) r = '{ACT_MOVE, S_HK};
      S_HK: begin
        if (c == K_COL) begin
          r = '{ACT_KEY, S_HV};
        end else if (c == K_MIN || c == K_ETC || c == K_E || c == K_G ||
                     c == K_T || c == K_P || c == K_H) begin
          r = '{ACT_MOVE, S_HK};
        end
      end
      S_HV: begin
        // A value ends on CR or LF; after CR the parser still expects LF.
        if (c == K_CR) begin
          r = '{ACT_KEY, S_ER};
        end else if (c == K_LF) begin
          r = '{ACT_KEY, S_HK};
        end else if (c != K_NUL && c != K_WHT && c != K_O && c != K_S) begin
          r = '{ACT_MOVE, S_HV};
        end
      end
      default: r.act = ACT_REJECT;
    endcase
    return r;
  endfunction

  state_t                 state;
  state_t                 state_next;
  logic [COUNT_WIDTH-1:0] byte_count;
  logic [COUNT_WIDTH-1:0] byte_count_next;
  step_t                  step;
  logic                   fire;
  logic                   ok;
  event_kind_t            kind;
  logic [3:0]             value;
  logic [3:0]             digit;

  assign q_ready = !result.valid || result.ready;
  assign fire = q_valid && q_ready;
  assign byte_count_next = byte_count + COUNT_WIDTH'(1);
  assign digit = 4'(q_item.data_byte - DIGIT_ZERO);

  always_comb begin
    step = next_step(state, q_item.cls);
    state_next = step.target;
    ok = 1'b1;
    kind = EV_NONE;
    value = 4'd0;
    unique case (step.act)
      ACT_MOVE: kind = EV_NONE;
      ACT_GET: begin
        kind = EV_METHOD;
        value = METHOD_GET;
      end
      ACT_POST: begin
        kind = EV_METHOD;
        value = METHOD_POST;
      end
      ACT_PATH: kind = EV_PATH;
      ACT_MAJ: begin
        kind = EV_MAJOR;
        value = digit;
      end
      ACT_MIN: begin
        kind = EV_MINOR;
        value = digit;
      end
      ACT_KEY: kind = (state == S_HV) ? EV_VALUE : EV_KEY;
      ACT_REJECT: ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_GO;
      byte_count <= '0;
      result.valid <= 1'b0;
    end else begin
      if (fire) begin
        state <= state_next;
        byte_count <= byte_count_next;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.accepted <= ok;
      result.event_kind <= kind;
      result.event_value <= value;
      result.byte_position <= POS_WIDTH'(byte_count_next);
    end
  end

endmodule

`default_nettype wire

@@ rtl/http_request_head_parser_core.sv @@
// Top level of the HTTP request head parser.
`default_nettype none

// Takes one byte of an HTTP request head per item and returns one result item per byte:
// whether the byte fits the request grammar, the event it completes (method, path end,
// version digits, header key or value end) and the running byte count. A new byte can be
// accepted every cycle while the queue has room and the result register is not held by
// back-pressure. Each byte is classified and written into the two-entry queue behind the
// classifier; the parser then looks it up in its combinational state table and writes its
// result item into the result register. A rejected byte leaves the parser state as it was,
// so the stream may continue after it.
module http_request_head_parser_core (
  input wire logic  clk,
  input wire logic  rst,
  hrp_in_if.sink    data,
  hrp_out_if.source result
);
  import hrp_pkg::*;

  hrp_item_t q_item;
  logic      q_valid;
  logic      q_ready;

  hrp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .data    (data),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  hrp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .result  (result)
  );

`ifndef SYNTHESIS
  a_event_implies_accept: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.event_kind != EV_NONE |-> result.accepted)
    else $error("event reported on a rejected byte");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.accepted |-> result.event_value == 4'd0)
    else $error("rejected byte carries an event value");

  a_full_queue_has_data: assert property (@(posedge clk) disable iff (rst)
    !data.ready |-> q_valid)
    else $error("input stalled while the queue is empty");
`endif

endmodule

`default_nettype wire
